// ===== sv/adw_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// adw_pkg: shared types and constants for the distortion waveshaper
// Register map, mode codes, sequencer states and the tanh table helper.
// ----------------------------------------------------------------------------
package adw_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 17;

    localparam logic [CFG_IDX_W-1:0] REG_MODE        = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DRIVE_GAIN  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WET_MIX     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CRUSH_BITS  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_HOLD_PERIOD = 3'd4;

    localparam logic [2:0] MODE_CLIP    = 3'd0;
    localparam logic [2:0] MODE_TANH    = 3'd1;
    localparam logic [2:0] MODE_FOLD    = 3'd2;
    localparam logic [2:0] MODE_CRUSH   = 3'd3;
    localparam logic [2:0] MODE_RECTIFY = 3'd4;
    localparam logic [2:0] MODE_SCREAM  = 3'd5;

    localparam logic [15:0] RST_DRIVE_GAIN  = 16'd2048;
    localparam logic [16:0] MIX_UNITY       = 17'd65536;
    localparam logic [4:0]  RST_CRUSH_BITS  = 5'd8;
    localparam logic [8:0]  RST_HOLD_PERIOD = 9'd1;

    localparam logic signed [17:0] W_SHAPED = 18'sd45875;
    localparam logic signed [17:0] W_FOLDED = 18'sd19661;

    localparam longint unsigned EXP_ONE = 64'd1 << 30;

    typedef struct packed {
        logic [2:0]  mode;
        logic [15:0] drive_gain;
        logic [16:0] wet_mix;
        logic [4:0]  crush_bits;
        logic [8:0]  hold_period;
    } cfg_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DRV,
        ST_DREG,
        ST_SHP,
        ST_TMUL,
        ST_TADD,
        ST_SW1,
        ST_SW2,
        ST_SW3,
        ST_MIXD,
        ST_MIXW,
        ST_MIXS,
        ST_OUT
    } state_t;

    // exp(-a) in Q.30, a given in Q.30 as 2x
    function automatic longint unsigned tanh_exp(longint unsigned a);
        longint unsigned u;
        longint unsigned t2;
        longint unsigned t3;
        longint unsigned t4;
        longint unsigned e;
        int k;
        u  = a >> 10;
        t2 = (u * u) >> 31;
        t3 = ((t2 * u) >> 30) / 3;
        t4 = ((t3 * u) >> 30) / 4;
        e  = EXP_ONE - u + t2 - t3 + t4;
        for (k = 0; k < 10; k++)
        begin
            e = (e * e + (EXP_ONE >> 1)) >> 30;
        end
        return e;
    endfunction

endpackage
`default_nettype wire

// ===== sv/adw_ifs.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// adw_ifs: channel interfaces
// Sample input, sample output and register write channels.
// ----------------------------------------------------------------------------
interface adw_in_if #(parameter int W = 24) ();
    logic                valid;
    logic                ready;
    logic signed [W-1:0] dry_sample;
    modport source (output valid, output dry_sample, input ready);
    modport sink (input valid, input dry_sample, output ready);
endinterface

interface adw_out_if #(parameter int W = 24) ();
    logic                valid;
    logic                ready;
    logic signed [W-1:0] wet_sample;
    logic                saturated;
    modport source (output valid, output wet_sample, output saturated, input ready);
    modport sink (input valid, input wet_sample, input saturated, output ready);
endinterface

interface adw_cfg_if ();
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [16:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ===== sv/adw_regs.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// adw_regs: configuration register file
// Takes register write transfers and holds the shaping settings.
// ----------------------------------------------------------------------------
module adw_regs (
    input  wire logic      clk,
    input  wire logic      rst_n,
    adw_cfg_if.sink        cfg,
    output adw_pkg::cfg_t  settings
);
    import adw_pkg::*;

    cfg_t settings_reg;

    assign cfg.ready = 1'b1;
    assign settings  = settings_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            settings_reg.mode        <= MODE_CLIP;
            settings_reg.drive_gain  <= RST_DRIVE_GAIN;
            settings_reg.wet_mix     <= MIX_UNITY;
            settings_reg.crush_bits  <= RST_CRUSH_BITS;
            settings_reg.hold_period <= RST_HOLD_PERIOD;
        end
        else if (cfg.valid && cfg.ready)
        begin
            case (cfg.index)
                REG_MODE:        settings_reg.mode        <= cfg.data[2:0];
                REG_DRIVE_GAIN:  settings_reg.drive_gain  <= cfg.data[15:0];
                REG_WET_MIX:     settings_reg.wet_mix     <= cfg.data;
                REG_CRUSH_BITS:  settings_reg.crush_bits  <= cfg.data[4:0];
                REG_HOLD_PERIOD: settings_reg.hold_period <= cfg.data[8:0];
                default:         ;
            endcase
        end
    end
endmodule
`default_nettype wire

// ===== sv/adw_mul.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// adw_mul: shared signed multiplier
// One registered product per cycle for every product of the sequencer.
// ----------------------------------------------------------------------------
module adw_mul #(
    parameter int AW = 30,
    parameter int BW = 18
) (
    input  wire logic                  clk,
    input  wire logic signed [AW-1:0]  a,
    input  wire logic signed [BW-1:0]  b,
    output logic signed [AW+BW-1:0]    prod
);
    logic signed [AW+BW-1:0] prod_reg;

    assign prod = prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= a * b;
    end
endmodule
`default_nettype wire

// ===== sv/adw_tanh.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// adw_tanh: tanh table lookup
// Splits |v| into index and 16-bit fraction, registers the lower entry and its step.
// ----------------------------------------------------------------------------
module adw_tanh #(
    parameter int SB = 24,
    parameter int N  = 256
) (
    input  wire logic                 clk,
    input  wire logic                 load,
    input  wire logic signed [SB+7:0] v,
    output logic [SB-1:0]             lo,
    output logic signed [SB:0]        diff,
    output logic [15:0]               frac,
    output logic                      neg
);
    import adw_pkg::*;

    localparam int FRAC = SB - 1;
    localparam int VW   = SB + 8;
    localparam int NW   = $clog2(N + 1);
    localparam int PW   = VW + NW;
    localparam logic [VW-1:0] LIM = VW'(1) << (FRAC + 2);

    logic [FRAC:0]   tab [0:N];
    logic [VW-1:0]   mag;
    logic [PW-1:0]   p;
    logic [NW-1:0]   idx;
    logic [NW-1:0]   idx_hi;
    logic            full;
    logic [FRAC:0]   lo_reg;
    logic signed [FRAC+1:0] diff_reg;
    logic [15:0]     frac_reg;
    logic            neg_reg;

    for (genvar g = 0; g <= N; g++)
    begin : g_tab
        localparam longint unsigned TA = ((64'(g) * 64'd8) << 30) / N;
        localparam longint unsigned TE = tanh_exp(TA);
        localparam longint unsigned TV =
            (((EXP_ONE - TE) << FRAC) + ((EXP_ONE + TE) >> 1)) / (EXP_ONE + TE);
        assign tab[g] = TV[FRAC:0];
    end

    always_comb
    begin
        mag    = v[VW-1] ? VW'(-v) : VW'(v);
        full   = (mag >= LIM);
        p      = PW'(mag) * PW'(N);
        idx    = NW'(p >> (FRAC + 2));
        idx_hi = idx + NW'(1);
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            neg_reg  <= v[VW-1];
            frac_reg <= p[FRAC+1:FRAC-14];
            if (full)
            begin
                lo_reg   <= tab[N];
                diff_reg <= '0;
            end
            else
            begin
                lo_reg   <= tab[idx];
                diff_reg <= $signed({1'b0, tab[idx_hi]}) - $signed({1'b0, tab[idx]});
            end
        end
    end

    assign lo   = lo_reg;
    assign diff = diff_reg;
    assign frac = frac_reg;
    assign neg  = neg_reg;
endmodule
`default_nettype wire

// ===== sv/adw_seq.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// adw_seq: sequencer and datapath
// Steps one sample through drive, shaping and mix on the shared multiplier.
// ----------------------------------------------------------------------------
module adw_seq #(
    parameter int SB = 24,
    parameter int N  = 256
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire adw_pkg::cfg_t settings,
    adw_in_if.sink             dry,
    adw_out_if.source          wet
);
    import adw_pkg::*;

    localparam int FRAC = SB - 1;
    localparam int DW   = SB + 6;
    localparam int VW   = SB + 8;
    localparam int PW   = DW + 18;
    localparam int AW   = DW + 19;

    localparam logic signed [DW-1:0] ONE_D   = DW'(1) <<< FRAC;
    localparam logic signed [DW-1:0] THREE_D = ONE_D + (ONE_D <<< 1);
    localparam logic [FRAC+1:0]      ONE_U   = (FRAC+2)'(1) << FRAC;
    localparam logic [FRAC+1:0]      TWO_U   = (FRAC+2)'(1) << (FRAC + 1);
    localparam logic signed [AW-1:0] RND     = AW'(32768);
    localparam logic signed [AW-1:0] MAX_A   = (AW'(1) <<< FRAC) - AW'(1);
    localparam logic signed [AW-1:0] MIN_A   = -(AW'(1) <<< FRAC);

    state_t state_reg;
    state_t state_next;

    logic signed [SB-1:0] x_reg;
    logic signed [DW-1:0] d_reg;
    logic signed [DW-1:0] w_reg;
    logic signed [DW-1:0] s_reg;
    logic signed [DW-1:0] f_reg;
    logic signed [AW-1:0] acc_reg;
    logic signed [DW-1:0] held_reg;
    logic [8:0]           cnt_reg;
    logic signed [SB-1:0] out_sample_reg;
    logic                 out_sat_reg;
    logic                 out_valid_reg;

    logic signed [DW-1:0] mul_a;
    logic signed [17:0]   mul_b;
    logic signed [PW-1:0] prod;

    logic [16:0]          mix_m;
    logic signed [VW-1:0] v3;
    logic signed [VW-1:0] tanh_v;
    logic                 tanh_load;
    logic [SB-1:0]        t_lo;
    logic signed [SB:0]   t_diff;
    logic [15:0]          t_frac;
    logic                 t_neg;

    logic [4:0]           cb;
    logic [4:0]           sh;
    logic [DW-1:0]        dmag;
    logic [DW:0]          half;
    logic [DW:0]          qsum;
    logic [DW:0]          qmask;
    logic [DW-1:0]        q;
    logic signed [DW-1:0] held_new;
    logic [8:0]           cnt1;
    logic                 resample;
    logic signed [DW-1:0] shaped;

    logic [FRAC:0]        y;
    logic signed [DW-1:0] sy;
    logic signed [DW-1:0] s2;
    logic signed [AW-1:0] wsum;
    logic signed [AW-1:0] blend;

    function automatic logic signed [DW-1:0] fold_v(logic signed [VW-1:0] h);
        logic [FRAC+1:0] u;
        u = h[FRAC+1:0] + ONE_U;
        if (u <= TWO_U)
            return $signed(DW'({1'b0, u})) - ONE_D;
        else
            return THREE_D - $signed(DW'({1'b0, u}));
    endfunction

    adw_mul #(.AW(DW), .BW(18)) u_mul (
        .clk  (clk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    adw_tanh #(.SB(SB), .N(N)) u_tanh (
        .clk  (clk),
        .load (tanh_load),
        .v    (tanh_v),
        .lo   (t_lo),
        .diff (t_diff),
        .frac (t_frac),
        .neg  (t_neg)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (dry.valid) state_next = ST_DRV;
            ST_DRV:  state_next = ST_DREG;
            ST_DREG: state_next = ST_SHP;
            ST_SHP:
            begin
                if (settings.mode == MODE_TANH || settings.mode == MODE_SCREAM)
                    state_next = ST_TMUL;
                else
                    state_next = ST_MIXD;
            end
            ST_TMUL: state_next = ST_TADD;
            ST_TADD: state_next = (settings.mode == MODE_SCREAM) ? ST_SW1 : ST_MIXD;
            ST_SW1:  state_next = ST_SW2;
            ST_SW2:  state_next = ST_SW3;
            ST_SW3:  state_next = ST_MIXD;
            ST_MIXD: state_next = ST_MIXW;
            ST_MIXW: state_next = ST_MIXS;
            ST_MIXS: state_next = ST_OUT;
            ST_OUT:  if (wet.ready) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs and multiplier operands
    always_comb
    begin
        dry.ready = (state_reg == ST_IDLE);
        tanh_load = (state_reg == ST_SHP);
        mul_a     = '0;
        mul_b     = '0;
        case (state_reg)
            ST_DRV:
            begin
                mul_a = DW'(x_reg);
                mul_b = $signed({2'b00, settings.drive_gain});
            end
            ST_TMUL:
            begin
                mul_a = DW'(t_diff);
                mul_b = $signed({2'b00, t_frac});
            end
            ST_SW1:
            begin
                mul_a = s_reg;
                mul_b = W_SHAPED;
            end
            ST_SW2:
            begin
                mul_a = f_reg;
                mul_b = W_FOLDED;
            end
            ST_MIXD:
            begin
                mul_a = DW'(x_reg);
                mul_b = $signed({1'b0, MIX_UNITY - mix_m});
            end
            ST_MIXW:
            begin
                mul_a = w_reg;
                mul_b = $signed({1'b0, mix_m});
            end
            default: ;
        endcase
    end

    assign wet.valid      = out_valid_reg;
    assign wet.wet_sample = out_sample_reg;
    assign wet.saturated  = out_sat_reg;

    always_comb
    begin
        mix_m  = (settings.wet_mix > MIX_UNITY) ? MIX_UNITY : settings.wet_mix;
        v3     = VW'(d_reg) + (VW'(d_reg) <<< 1);
        tanh_v = (settings.mode == MODE_SCREAM) ? v3 : VW'(d_reg);

        if (settings.crush_bits < 5'd1)
            cb = 5'd1;
        else if (settings.crush_bits > 5'(FRAC))
            cb = 5'(FRAC);
        else
            cb = settings.crush_bits;
        sh       = 5'(FRAC) - cb;
        dmag     = d_reg[DW-1] ? DW'(-d_reg) : DW'(d_reg);
        half     = (sh == 5'd0) ? '0 : ((DW+1)'(1) << (sh - 5'd1));
        qsum     = {1'b0, dmag} + half;
        qmask    = ((DW+1)'(1) << sh) - (DW+1)'(1);
        q        = DW'(qsum & ~qmask);
        held_new = d_reg[DW-1] ? -$signed(q) : $signed(q);
        cnt1     = cnt_reg + 9'd1;
        resample = (cnt1 >= settings.hold_period);

        case (settings.mode)
            MODE_CLIP:
            begin
                if (d_reg > ONE_D)
                    shaped = ONE_D;
                else if (d_reg < -ONE_D)
                    shaped = -ONE_D;
                else
                    shaped = d_reg;
            end
            MODE_FOLD:    shaped = fold_v(VW'(d_reg));
            MODE_CRUSH:   shaped = resample ? held_new : held_reg;
            MODE_RECTIFY: shaped = d_reg[DW-1] ? -d_reg : d_reg;
            default:      shaped = '0;
        endcase

        y  = t_lo + (FRAC+1)'(prod >>> 16);
        sy = t_neg ? -$signed(DW'({1'b0, y})) : $signed(DW'({1'b0, y}));
        s2 = sy <<< 1;
        if (s2 > ONE_D)
            s2 = ONE_D;
        else if (s2 < -ONE_D)
            s2 = -ONE_D;

        wsum  = acc_reg + AW'(prod) + RND;
        blend = wsum >>> 16;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            held_reg      <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_SHP && settings.mode == MODE_CRUSH)
            begin
                if (resample)
                begin
                    held_reg <= held_new;
                    cnt_reg  <= '0;
                end
                else
                begin
                    cnt_reg <= cnt1;
                end
            end
            if (state_reg == ST_MIXS)
                out_valid_reg <= 1'b1;
            else if (wet.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE: x_reg <= dry.dry_sample;
            ST_DREG: d_reg <= DW'(prod >>> 11);
            ST_SHP:  w_reg <= shaped;
            ST_TADD:
            begin
                w_reg <= sy;
                s_reg <= s2;
                f_reg <= fold_v(v3 >>> 1);
            end
            ST_SW2:  acc_reg <= AW'(prod);
            ST_SW3:  w_reg <= DW'(wsum >>> 16);
            ST_MIXW: acc_reg <= AW'(prod);
            ST_MIXS:
            begin
                if (blend > MAX_A)
                begin
                    out_sample_reg <= SB'(MAX_A);
                    out_sat_reg    <= 1'b1;
                end
                else if (blend < MIN_A)
                begin
                    out_sample_reg <= SB'(MIN_A);
                    out_sat_reg    <= 1'b1;
                end
                else
                begin
                    out_sample_reg <= SB'(blend);
                    out_sat_reg    <= 1'b0;
                end
            end
            default: ;
        endcase
    end
endmodule
`default_nettype wire

// ===== sv/audio_distortion_waveshaper.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// audio_distortion_waveshaper: fixed-point distortion with bit crusher
// Drive gain, waveshaping by mode, dry/wet blend, saturation to Q1.23.
//
//   channel  role    payload
//   dry      sink    dry_sample
//   wet      source  wet_sample, saturated
//   cfg      sink    index, data (register writes)
//
// Clip, fold, crush and rectify pass the drive, shaping and mix states; tanh
// adds the table interpolation states and scream also the weighting states, all
// on the single shared multiplier. A new sample waits until the result is taken.
// dry.ready is high only while the sequencer is idle and no result is held.
// A stalled result holds until wet.ready. Reset restores register
// defaults and clears the crush hold state; no clearing pass.
// ----------------------------------------------------------------------------
module audio_distortion_waveshaper #(
    parameter int TANH_TABLE_ENTRIES = 256,
    parameter int SAMPLE_BITS        = 24
) (
    input  wire logic clk,
    input  wire logic rst_n,
    adw_in_if.sink    dry,
    adw_out_if.source wet,
    adw_cfg_if.sink   cfg
);
    import adw_pkg::*;

    cfg_t settings;

    adw_regs u_regs (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .settings (settings)
    );

    adw_seq #(.SB(SAMPLE_BITS), .N(TANH_TABLE_ENTRIES)) u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .settings (settings),
        .dry      (dry),
        .wet      (wet)
    );

    a_busy_after_in: assert property (@(posedge clk) disable iff (!rst_n)
        dry.valid && dry.ready |=> !dry.ready)
        else $error("input taken while busy");

    a_no_in_while_out: assert property (@(posedge clk) disable iff (!rst_n)
        wet.valid |-> !dry.ready)
        else $error("input ready while result pending");

    a_sat_at_rail: assert property (@(posedge clk) disable iff (!rst_n)
        wet.valid && wet.saturated |->
            (wet.wet_sample == {1'b0, {(SAMPLE_BITS-1){1'b1}}}) ||
            (wet.wet_sample == {1'b1, {(SAMPLE_BITS-1){1'b0}}}))
        else $error("saturation flag without rail value");
endmodule
`default_nettype wire

// ===== sim/tb_adw_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_adw_checker: result predictor and scoreboard for the waveshaper
// Watches the register, dry and wet channels, computes the expected wet
// sample and saturation flag per dry transfer and compares in order.
// ----------------------------------------------------------------------------
module tb_adw_checker
    import adw_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    adw_in_if  dry,
    adw_out_if wet,
    adw_cfg_if cfg,
    output int        fail_count,
    output int        pending_count,
    output int        result_count
);

    localparam int FB = 23;
    localparam int TAB_N = 256;
    localparam longint ONE = 64'sd1 <<< FB;

    typedef struct {
        logic signed [23:0] sample;
        logic               sat;
    } wet_exp_t;

    longint unsigned tanh_lut [0:TAB_N];
    wet_exp_t        wet_queue [$];

    logic [2:0]  cur_mode;
    logic [15:0] cur_drive;
    logic [16:0] cur_mix;
    logic [4:0]  cur_bits;
    logic [8:0]  cur_period;
    longint      crush_hold;
    logic [8:0]  crush_count;

    function automatic longint fdiv(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint tanh_lookup(longint v);
        longint unsigned mag;
        longint unsigned p;
        longint unsigned ix;
        longint unsigned fr;
        longint unsigned y;
        mag = (v < 0) ? -v : v;
        if (mag >= (64'd4 << FB))
            y = tanh_lut[TAB_N];
        else
        begin
            p  = mag * TAB_N;
            ix = p >> (FB + 2);
            fr = (p & ((64'd4 << FB) - 1)) >> (FB - 14);
            y  = tanh_lut[ix] + (((tanh_lut[ix + 1] - tanh_lut[ix]) * fr) >> 16);
        end
        return (v < 0) ? -longint'(y) : longint'(y);
    endfunction

    function automatic longint clamp_unit(longint v);
        if (v > ONE)
            return ONE;
        if (v < -ONE)
            return -ONE;
        return v;
    endfunction

    function automatic longint fold_tri(longint v);
        longint u;
        u = (v + ONE) & ((64'sd4 <<< FB) - 1);
        if (u <= 2 * ONE)
            return u - ONE;
        return 3 * ONE - u;
    endfunction

    function automatic wet_exp_t predict_wet(logic signed [23:0] x_in);
        wet_exp_t r;
        longint   x;
        longint   d;
        longint   w;
        longint   m;
        longint   b;
        longint   sv;
        longint   fv;
        longint unsigned mag;
        longint unsigned hf;
        int       bits;
        int       sh;
        x = x_in;
        d = fdiv(x * longint'(cur_drive), 11);
        case (cur_mode)
            MODE_CLIP:    w = clamp_unit(d);
            MODE_TANH:    w = tanh_lookup(d);
            MODE_FOLD:    w = fold_tri(d);
            MODE_RECTIFY: w = (d < 0) ? -d : d;
            MODE_SCREAM:
            begin
                sv = clamp_unit(2 * tanh_lookup(3 * d));
                fv = fold_tri(fdiv(3 * d, 1));
                w  = fdiv(longint'(W_SHAPED) * sv + longint'(W_FOLDED) * fv + 32768, 16);
            end
            MODE_CRUSH:
            begin
                crush_count = crush_count + 9'd1;
                if (crush_count >= cur_period)
                begin
                    bits = (cur_bits < 1) ? 1 : ((cur_bits > FB) ? FB : int'(cur_bits));
                    sh   = FB - bits;
                    hf   = (sh != 0) ? (64'd1 << (sh - 1)) : 0;
                    mag  = (d < 0) ? -d : d;
                    mag  = ((mag + hf) >> sh) << sh;
                    crush_hold  = (d < 0) ? -longint'(mag) : longint'(mag);
                    crush_count = '0;
                end
                w = crush_hold;
            end
            default:      w = 0;
        endcase
        m = (cur_mix > MIX_UNITY) ? 65536 : longint'(cur_mix);
        b = fdiv(x * (65536 - m) + w * m + 32768, 16);
        r.sat = 1'b0;
        if (b > ONE - 1)
        begin
            b = ONE - 1;
            r.sat = 1'b1;
        end
        if (b < -ONE)
        begin
            b = -ONE;
            r.sat = 1'b1;
        end
        r.sample = b[23:0];
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    initial
    begin
        longint unsigned a;
        longint unsigned e;
        for (int i = 0; i <= TAB_N; i++)
        begin
            a = ((64'd8 * i) << 30) / TAB_N;
            e = tanh_exp(a);
            tanh_lut[i] = (((EXP_ONE - e) << FB) + ((EXP_ONE + e) >> 1)) / (EXP_ONE + e);
        end
    end

    assign pending_count = wet_queue.size();

    always @(posedge clk or negedge rst_n)
    begin
        wet_exp_t want;
        if (!rst_n)
        begin
            cur_mode    <= MODE_CLIP;
            cur_drive   <= RST_DRIVE_GAIN;
            cur_mix     <= MIX_UNITY;
            cur_bits    <= RST_CRUSH_BITS;
            cur_period  <= RST_HOLD_PERIOD;
            crush_hold  = 0;
            crush_count = '0;
            fail_count   = 0;
            result_count = 0;
            wet_queue.delete();
        end
        else
        begin
            if (wet.valid && wet.ready)
            begin
                result_count++;
                if (wet_queue.size() == 0)
                    report_mismatch("unexpected result", wet.wet_sample, 0);
                else
                begin
                    want = wet_queue.pop_front();
                    if (wet.wet_sample !== want.sample)
                        report_mismatch("wet_sample", wet.wet_sample, want.sample);
                    if (wet.saturated !== want.sat)
                        report_mismatch("saturated", wet.saturated, want.sat);
                end
            end
            if (dry.valid && dry.ready)
                wet_queue.push_back(predict_wet(dry.dry_sample));
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    REG_MODE:        cur_mode   <= cfg.data[2:0];
                    REG_DRIVE_GAIN:  cur_drive  <= cfg.data[15:0];
                    REG_WET_MIX:     cur_mix    <= cfg.data;
                    REG_CRUSH_BITS:  cur_bits   <= cfg.data[4:0];
                    REG_HOLD_PERIOD: cur_period <= cfg.data[8:0];
                    default: ;
                endcase
            end
        end
    end

endmodule

// ===== sim/tb_audio_distortion_waveshaper.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_audio_distortion_waveshaper: testbench top for the waveshaper
// Directed and random samples across all modes and register settings, with
// random gaps on both channels; the checker compares every result.
// ----------------------------------------------------------------------------
module tb_audio_distortion_waveshaper;
    import adw_pkg::*;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   pending_count;
    int   result_count;
    int   sent_count;
    int   cfg_count;

    adw_in_if  #(.W(24)) dry ();
    adw_out_if #(.W(24)) wet ();
    adw_cfg_if           cfg ();

    audio_distortion_waveshaper i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .dry   (dry),
        .wet   (wet),
        .cfg   (cfg)
    );

    tb_adw_checker i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .dry           (dry),
        .wet           (wet),
        .cfg           (cfg),
        .fail_count    (fail_count),
        .pending_count (pending_count),
        .result_count  (result_count)
    );

    initial
        clk = 1'b0;
    always #6 clk = ~clk;

    initial
    begin
        #200ms;
        $display("tb: failure");
        $finish;
    end

    // receiver stalls
    initial
    begin
        int gap;
        wet.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            gap = $urandom_range(0, 4);
            if (gap != 0)
            begin
                wet.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            wet.ready <= 1'b1;
            @(posedge clk);
            while (!wet.valid)
                @(posedge clk);
        end
    end

    task automatic write_reg(logic [2:0] idx, logic [16:0] value);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= value;
        @(posedge clk);
        while (!cfg.ready)
            @(posedge clk);
        cfg.valid <= 1'b0;
        @(posedge clk);
        cfg_count++;
    endtask

    task automatic send_sample(logic signed [23:0] s, bit no_gap);
        int gap;
        gap = no_gap ? 0 : $urandom_range(0, 4);
        if (gap != 0)
        begin
            dry.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        dry.valid      <= 1'b1;
        dry.dry_sample <= s;
        @(posedge clk);
        while (!dry.ready)
            @(posedge clk);
        sent_count++;
    endtask

    task automatic drain;
        int guard;
        guard = 0;
        dry.valid <= 1'b0;
        while (pending_count != 0 && guard < 100000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (20) @(posedge clk);
    endtask

    task automatic set_all(logic [2:0] md, logic [15:0] dg, logic [16:0] mx,
                           logic [4:0] cb, logic [8:0] hp);
        drain();
        write_reg(REG_MODE, 17'(md));
        write_reg(REG_DRIVE_GAIN, 17'(dg));
        write_reg(REG_WET_MIX, mx);
        write_reg(REG_CRUSH_BITS, 17'(cb));
        write_reg(REG_HOLD_PERIOD, 17'(hp));
    endtask

    function automatic logic signed [23:0] rand_sample();
        case ($urandom_range(0, 5))
            0: return 24'sh7FFFFF;
            1: return 24'sh800000;
            2: return 24'($signed($urandom_range(0, 4000)) - 2000);
            default: return 24'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] rand_drive();
        case ($urandom_range(0, 4))
            0: return 16'd2048;
            1: return 16'hFFFF;
            2: return 16'($urandom_range(0, 4096));
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [16:0] rand_mix();
        case ($urandom_range(0, 4))
            0: return MIX_UNITY;
            1: return 17'd0;
            2: return 17'h1FFFF;
            default: return 17'($urandom_range(0, 65536));
        endcase
    endfunction

    initial
    begin
        logic signed [23:0] edge_vals [6];
        int ph;
        rst_n          = 1'b0;
        dry.valid      = 1'b0;
        dry.dry_sample = '0;
        cfg.valid      = 1'b0;
        cfg.index      = '0;
        cfg.data       = '0;
        sent_count     = 0;
        cfg_count      = 0;
        edge_vals = '{24'sh7FFFFF, 24'sh800000, 24'sh000000, 24'shFFFFFF,
                      24'sh400000, 24'shC00000};
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset defaults: clip at unity, full scale passes without clamping
        send_sample(24'sh7FFFFF, 1'b0);
        send_sample(24'sh800000, 1'b0);
        for (int md = 0; md < 8; md++)
        begin
            set_all(3'(md), 16'd8192, MIX_UNITY, 5'd4, 9'd1);
            send_sample(edge_vals[md % 6], 1'b0);
            send_sample(edge_vals[(md + 3) % 6], 1'b0);
        end
        // crush extremes: zero bits, bits above range, zero period, lowered period
        set_all(MODE_CRUSH, 16'd2048, MIX_UNITY, 5'd0, 9'd0);
        send_sample(24'sh123456, 1'b0);
        drain();
        write_reg(REG_CRUSH_BITS, 17'd31);
        send_sample(24'shA54321, 1'b0);
        set_all(MODE_CRUSH, 16'd2048, 17'h1FFFF, 5'd23, 9'd256);
        repeat (3) send_sample(rand_sample(), 1'b0);
        set_all(MODE_CRUSH, 16'd2048, 17'd0, 5'd1, 9'd1);
        send_sample(24'sh7FFFFF, 1'b0);

        // random phases; bit crush weighted with short hold periods
        for (ph = 0; ph < 50; ph++)
        begin
            set_all(($urandom_range(0, 3) == 0) ? MODE_CRUSH : 3'($urandom_range(0, 7)),
                    rand_drive(), rand_mix(), 5'($urandom),
                    ($urandom_range(0, 3) == 0) ? 9'($urandom) : 9'($urandom_range(0, 6)));
            if (ph == 25)
                drain();
            repeat (25) send_sample(rand_sample(), ph % 7 == 0);
        end

        drain();
        $display("covered %0d samples, %0d register writes, all 8 mode codes",
                 sent_count, cfg_count);
        $display("results checked: %0d, mismatches: %0d", result_count, fail_count);
        if (fail_count == 0 && pending_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ===== sim.f =====
sv/adw_pkg.sv
sv/adw_ifs.sv
sv/adw_regs.sv
sv/adw_mul.sv
sv/adw_tanh.sv
sv/adw_seq.sv
sv/audio_distortion_waveshaper.sv
sim/tb_adw_checker.sv
sim/tb_audio_distortion_waveshaper.sv
